// File: rtl/ttoi_pkg.sv
// shared types, constants and helpers for the text to integer reader
// used by every module of the block; depends on nothing
`default_nettype none

package ttoi_pkg;

	// field and register widths
	localparam int CH_W          = 8;
	localparam int ALPHA_W       = 64;
	localparam int CNT_W         = 5;
	localparam int POS_W         = 4;
	localparam int VALUE_W       = 64;
	localparam int DATA_W        = 64;
	localparam int ADDR_W        = 5;
	localparam int REG_IDX_W     = 2;
	localparam int SYM_LIMIT     = 16;
	localparam int MAX_DIGITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	// character codes
	localparam logic [CH_W-1:0] CHR_NUL   = 8'd0;
	localparam logic [CH_W-1:0] CHR_TAB   = 8'd9;
	localparam logic [CH_W-1:0] CHR_CR    = 8'd13;
	localparam logic [CH_W-1:0] CHR_BLANK = 8'd32;
	localparam logic [CH_W-1:0] CHR_PLUS  = 8'h2b;
	localparam logic [CH_W-1:0] CHR_MINUS = 8'h2d;

	// smallest usable radix
	localparam logic [CNT_W-1:0] MIN_DIGITS = 5'd2;

	// register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_LO = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_HI = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNT    = 2'd2;

	// class of one character as seen by the front
	typedef enum logic [2:0] {
		KIND_SPACE,
		KIND_PLUS,
		KIND_MINUS,
		KIND_DIGIT,
		KIND_OTHER
	} char_kind_t;

	// reader phase in the back
	typedef enum logic [1:0] {
		PH_SPACE,
		PH_DIGITS,
		PH_STOP
	} phase_t;

	// configuration as held in the register block
	typedef struct packed {
		logic [ALPHA_W-1:0] alpha_hi;
		logic [ALPHA_W-1:0] alpha_lo;
		logic [CNT_W-1:0]   count;
	} cfg_t;

	// one classified item travelling from front to back
	// digit is set whenever the character matches a symbol in use, whatever its kind
	typedef struct packed {
		char_kind_t       kind;
		logic [POS_W-1:0] pos;
		logic             digit;
		logic [CNT_W-1:0] count;
		logic             last;
		logic             base_ok;
	} qent_t;

	// whitespace test: tab to carriage return, and blank
	function automatic logic is_space(input logic [CH_W-1:0] c);
		return ((c >= CHR_TAB) && (c <= CHR_CR)) || (c == CHR_BLANK);
	endfunction

endpackage

`default_nettype wire

// File: rtl/ttoi_cfg.sv
// configuration registers behind the apb-style port
// depends on ttoi_pkg
`default_nettype none

module ttoi_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ttoi_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [ttoi_pkg::DATA_W-1:0]   pwdata,
	output logic      [ttoi_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output ttoi_pkg::cfg_t                     cfg
);

	logic [ttoi_pkg::REG_IDX_W-1:0] idx;
	logic                           wr_en;
	logic [ttoi_pkg::ALPHA_W-1:0]   alpha_lo_q;
	logic [ttoi_pkg::ALPHA_W-1:0]   alpha_hi_q;
	logic [ttoi_pkg::CNT_W-1:0]     count_q;

	// registers sit at 8-byte steps
	assign idx    = paddr[ttoi_pkg::ADDR_W-1:3];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_lo_q <= '0;
			alpha_hi_q <= '0;
			count_q    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				ttoi_pkg::REG_ALPHA_LO: alpha_lo_q <= pwdata;
				ttoi_pkg::REG_ALPHA_HI: alpha_hi_q <= pwdata;
				ttoi_pkg::REG_COUNT:    count_q    <= pwdata[ttoi_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			ttoi_pkg::REG_ALPHA_LO: prdata = alpha_lo_q;
			ttoi_pkg::REG_ALPHA_HI: prdata = alpha_hi_q;
			ttoi_pkg::REG_COUNT:    prdata = ttoi_pkg::DATA_W'(count_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.alpha_lo = alpha_lo_q;
	assign cfg.alpha_hi = alpha_hi_q;
	assign cfg.count    = count_q;

endmodule

`default_nettype wire

// File: rtl/ttoi_front.sv
// front: takes characters, looks them up in the alphabet and judges the alphabet
// depends on ttoi_pkg
`default_nettype none

module ttoi_front #(
	parameter int MAX_DIGITS = ttoi_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [ttoi_pkg::CH_W-1:0]  s_tdata,
	input  wire logic                       s_tlast,
	input  wire ttoi_pkg::cfg_t             cfg,
	input  wire logic                       q_full,
	output logic                            q_push,
	output ttoi_pkg::qent_t                 q_ent
);

	logic [2*ttoi_pkg::ALPHA_W-1:0] alpha;
	logic [ttoi_pkg::CH_W-1:0]      sym    [MAX_DIGITS];
	logic [MAX_DIGITS-1:0]          in_use;
	logic [MAX_DIGITS-1:0]          bad_sym;
	logic                           dup;
	logic                           hit;
	logic [ttoi_pkg::POS_W-1:0]     pos;
	logic                           count_ok;
	logic [ttoi_pkg::CH_W-1:0]      ch;
	ttoi_pkg::char_kind_t           kind;

	assign ch    = s_tdata;
	assign alpha = {cfg.alpha_hi, cfg.alpha_lo};

	// symbol lanes
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			sym[i]     = alpha[i*ttoi_pkg::CH_W +: ttoi_pkg::CH_W];
			in_use[i]  = ttoi_pkg::CNT_W'(i) < cfg.count;
			bad_sym[i] = (sym[i] == ttoi_pkg::CHR_NUL) || ttoi_pkg::is_space(sym[i]) ||
				(sym[i] == ttoi_pkg::CHR_PLUS) || (sym[i] == ttoi_pkg::CHR_MINUS);
		end
	end

	// repeated symbols among those in use
	always_comb begin
		dup = 1'b0;
		for (int i = 0; i < MAX_DIGITS; i++)
			for (int j = i + 1; j < MAX_DIGITS; j++)
				if (in_use[j] && (sym[i] == sym[j]))
					dup = 1'b1;
	end

	assign count_ok = (cfg.count >= ttoi_pkg::MIN_DIGITS) &&
		(cfg.count <= ttoi_pkg::CNT_W'(MAX_DIGITS));

	// lookup, lowest position wins
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
			if (in_use[i] && (sym[i] == ch)) begin
				hit = 1'b1;
				pos = ttoi_pkg::POS_W'(i);
			end
		end
	end

	// classify
	always_comb begin
		if (ttoi_pkg::is_space(ch))
			kind = ttoi_pkg::KIND_SPACE;
		else if (ch == ttoi_pkg::CHR_PLUS)
			kind = ttoi_pkg::KIND_PLUS;
		else if (ch == ttoi_pkg::CHR_MINUS)
			kind = ttoi_pkg::KIND_MINUS;
		else if (hit)
			kind = ttoi_pkg::KIND_DIGIT;
		else
			kind = ttoi_pkg::KIND_OTHER;
	end

	assign q_ent = '{
		kind:    kind,
		pos:     pos,
		digit:   hit,
		count:   cfg.count,
		last:    s_tlast,
		base_ok: count_ok && !(|(in_use & bad_sym)) && !dup
	};

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

endmodule

`default_nettype wire

// File: rtl/ttoi_queue.sv
// short queue of classified items between front and back
// depends on ttoi_pkg
`default_nettype none

module ttoi_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ttoi_pkg::qent_t  push_ent,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output ttoi_pkg::qent_t       head
);

	localparam int DEPTH = ttoi_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ttoi_pkg::qent_t    ent_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;

	assign full  = fill_q == CNT_W'(DEPTH);
	assign valid = fill_q != '0;
	assign head  = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_ent;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ttoi_back.sv
// back: reader phase, sign and accumulator, and the result register
// depends on ttoi_pkg
`default_nettype none

module ttoi_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire ttoi_pkg::qent_t               q_head,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [ttoi_pkg::VALUE_W-1:0]  m_tdata,
	output logic                               m_tuser
);

	ttoi_pkg::phase_t               phase_q;
	ttoi_pkg::phase_t               phase_d;
	logic                           neg_q;
	logic [ttoi_pkg::VALUE_W-1:0]   acc_q;
	logic [ttoi_pkg::VALUE_W-1:0]   acc_next;
	logic [ttoi_pkg::VALUE_W-1:0]   mag;
	logic                           neg;
	logic                           add_en;
	logic                           sign_en;
	logic                           out_valid_q;
	logic [ttoi_pkg::VALUE_W-1:0]   out_mag_q;
	logic                           out_neg_q;
	logic                           out_ok_q;

	// a last item needs room in the result register
	assign q_pop = q_valid && (!q_head.last || !out_valid_q || m_tready);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (q_pop) begin
			unique case (phase_q)
				ttoi_pkg::PH_SPACE: begin
					case (q_head.kind) inside
						ttoi_pkg::KIND_SPACE: phase_d = ttoi_pkg::PH_SPACE;
						ttoi_pkg::KIND_PLUS, ttoi_pkg::KIND_MINUS,
						ttoi_pkg::KIND_DIGIT: phase_d = ttoi_pkg::PH_DIGITS;
						default: phase_d = ttoi_pkg::PH_STOP;
					endcase
				end
				// among digits any symbol in use counts, even a blank or a sign
				ttoi_pkg::PH_DIGITS: begin
					phase_d = q_head.digit ? ttoi_pkg::PH_DIGITS : ttoi_pkg::PH_STOP;
				end
				ttoi_pkg::PH_STOP: phase_d = ttoi_pkg::PH_STOP;
				default: phase_d = ttoi_pkg::PH_SPACE;
			endcase
			if (q_head.last)
				phase_d = ttoi_pkg::PH_SPACE;
		end
	end

	// phase-dependent actions
	always_comb begin
		add_en  = 1'b0;
		sign_en = 1'b0;
		unique case (phase_q)
			ttoi_pkg::PH_SPACE: begin
				add_en  = q_pop && (q_head.kind == ttoi_pkg::KIND_DIGIT);
				sign_en = q_pop && ((q_head.kind == ttoi_pkg::KIND_PLUS) ||
					(q_head.kind == ttoi_pkg::KIND_MINUS));
			end
			ttoi_pkg::PH_DIGITS: add_en = q_pop && q_head.digit;
			default: ;
		endcase
	end

	// one multiply-add per digit, wrapping at the value width
	assign acc_next = acc_q * ttoi_pkg::VALUE_W'(q_head.count) +
		ttoi_pkg::VALUE_W'(q_head.pos);
	assign mag = add_en ? acc_next : acc_q;
	assign neg = sign_en ? (q_head.kind == ttoi_pkg::KIND_MINUS) : neg_q;

	// reader state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ttoi_pkg::PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (q_pop) begin
				acc_q <= q_head.last ? '0 : mag;
				neg_q <= q_head.last ? 1'b0 : neg;
			end
		end
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_pop && q_head.last)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) begin
			out_mag_q <= mag;
			out_neg_q <= neg;
			out_ok_q  <= q_head.base_ok;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = !out_ok_q ? '0 : (out_neg_q ? (~out_mag_q + 1'b1) : out_mag_q);

endmodule

`default_nettype wire

// File: rtl/text_to_integer_any_base_core.sv
// top level of the text to integer reader over a configurable alphabet
// depends on ttoi_pkg, ttoi_cfg, ttoi_front, ttoi_queue and ttoi_back
`default_nettype none

// Reads a string, one character per item on the slave stream, as a signed
// integer written in an alphabet of up to 16 symbols held in registers 0 and 1,
// with the radix in register 2. Leading whitespace is skipped, one sign is taken,
// digits accumulate with 64-bit wraparound and reading stops at the first
// non-symbol. The item with tlast gives one result: tdata is the value (0 when
// the alphabet is invalid) and tuser says whether the alphabet is valid. The
// block takes one character every cycle while the queue is not full: the front
// classifies it with 16 parallel compares, a two-entry queue holds it, and the
// back does one multiply-add per cycle unless a last character waits for room.
// A result is registered when the back takes its last character; a result left
// waiting stalls the back only when a further last character arrives, and input
// stalls only once the queue is full. No clearing pass follows reset.
module text_to_integer_any_base_core #(
	parameter int MAX_DIGITS = ttoi_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// apb-style configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ttoi_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [ttoi_pkg::DATA_W-1:0]   pwdata,
	output logic      [ttoi_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	// character stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [ttoi_pkg::CH_W-1:0]     s_tdata,   // [7:0] ch
	input  wire logic                          s_tlast,
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [ttoi_pkg::VALUE_W-1:0]  m_tdata,   // [63:0] value
	output logic                               m_tuser    // [0] base_ok
);

	ttoi_pkg::cfg_t  cfg;
	ttoi_pkg::qent_t push_ent;
	ttoi_pkg::qent_t head;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;

	ttoi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ttoi_front #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cfg      (cfg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_ent    (push_ent)
	);

	ttoi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (push_ent),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head)
	);

	ttoi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// File: rtl/ttoi_checker.sv
// port-level checks for the text to integer reader, bound to the top level
// depends on ttoi_pkg and text_to_integer_any_base_core
`default_nettype none

module ttoi_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          psel,
	input wire logic                          penable,
	input wire logic                          pwrite,
	input wire logic [ttoi_pkg::ADDR_W-1:0]   paddr,
	input wire logic [ttoi_pkg::DATA_W-1:0]   pwdata,
	input wire logic [ttoi_pkg::DATA_W-1:0]   prdata,
	input wire logic                          pready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [ttoi_pkg::VALUE_W-1:0]  m_tdata,
	input wire logic                          m_tuser
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an invalid alphabet always gives zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("non-zero value with invalid alphabet");

	// alphabet low register reads back what was written
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite && pready &&
			(paddr[ttoi_pkg::ADDR_W-1:3] == ttoi_pkg::REG_ALPHA_LO)) &&
		psel && !pwrite && (paddr[ttoi_pkg::ADDR_W-1:3] == ttoi_pkg::REG_ALPHA_LO)
		|-> prdata == $past(pwdata))
		else $error("alphabet register read back wrong");

endmodule

bind text_to_integer_any_base_core ttoi_checker u_ttoi_checker (.*);

`default_nettype wire

// File: test/text_to_integer_any_base_core_tb.sv
// self-checking bench for text_to_integer_any_base_core: a directed table of strings, then
// random alphabets and strings, each result compared with a fixed value or a predictor kept
// in the bench; depends on ttoi_pkg and the core under test
`default_nettype none

module text_to_integer_any_base_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int CALM_AFTER   = 1600;
	localparam int SETTLE       = 8;
	localparam logic [ttoi_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [ttoi_pkg::VALUE_W-1:0] value;
		logic                         base_ok;
	} result_t;

	// one line of the directed table: a register write or a character
	typedef struct packed {
		logic                           is_reg;
		logic [ttoi_pkg::REG_IDX_W-1:0] idx;
		logic [ttoi_pkg::DATA_W-1:0]    data;
		logic [ttoi_pkg::CH_W-1:0]      ch;
		logic                           last;
		logic                           fixed;
		result_t                        res;
	} row_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           psel     = 1'b0;
	logic                           penable  = 1'b0;
	logic                           pwrite   = 1'b0;
	logic [ttoi_pkg::ADDR_W-1:0]    paddr    = '0;
	logic [ttoi_pkg::DATA_W-1:0]    pwdata   = '0;
	logic [ttoi_pkg::DATA_W-1:0]    prdata;
	logic                           pready;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [ttoi_pkg::CH_W-1:0]      s_tdata  = '0;   // [7:0] ch
	logic                           s_tlast  = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [ttoi_pkg::VALUE_W-1:0]   m_tdata;         // [63:0] value
	logic                           m_tuser;         // [0] base_ok

	// bench copy of the registers and the reader state
	logic [ttoi_pkg::ALPHA_W-1:0]   alpha_lo_m = '0;
	logic [ttoi_pkg::ALPHA_W-1:0]   alpha_hi_m = '0;
	logic [ttoi_pkg::CNT_W-1:0]     count_m    = '0;
	ttoi_pkg::phase_t               phase_m    = ttoi_pkg::PH_SPACE;
	logic                           neg_m      = 1'b0;
	logic [ttoi_pkg::VALUE_W-1:0]   acc_m      = '0;

	result_t              pending_results[$];
	logic                 use_fixed = 1'b0;
	result_t              fixed_res = '0;
	int                   cycle_n    = 0;
	int                   errors     = 0;
	int                   items_n    = 0;
	int                   stall_left = 0;
	logic                 calm   = 1'b0;
	logic                 bursty = 1'b1;

	text_to_integer_any_base_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// symbol for digit value i
	function automatic logic [ttoi_pkg::CH_W-1:0] symbol(input int i);
		if (i < 8) return alpha_lo_m[8*i +: 8];
		return alpha_hi_m[8*(i-8) +: 8];
	endfunction

	function automatic logic blank(input logic [ttoi_pkg::CH_W-1:0] c);
		return ((c >= ttoi_pkg::CHR_TAB) && (c <= ttoi_pkg::CHR_CR)) ||
			(c == ttoi_pkg::CHR_BLANK);
	endfunction

	// lowest digit value whose symbol is c, or -1
	function automatic int digit_of(input logic [ttoi_pkg::CH_W-1:0] c);
		int n;
		n = (count_m > ttoi_pkg::MAX_DIGITS_DEF) ? ttoi_pkg::MAX_DIGITS_DEF : int'(count_m);
		for (int i = 0; i < n; i++)
			if (symbol(i) == c) return i;
		return -1;
	endfunction

	function automatic logic alphabet_good();
		logic [ttoi_pkg::CH_W-1:0] s;
		if ((count_m < ttoi_pkg::MIN_DIGITS) || (count_m > ttoi_pkg::MAX_DIGITS_DEF))
			return 1'b0;
		for (int i = 0; i < int'(count_m); i++) begin
			s = symbol(i);
			if ((s == ttoi_pkg::CHR_NUL) || blank(s) || (s == ttoi_pkg::CHR_PLUS) ||
					(s == ttoi_pkg::CHR_MINUS))
				return 1'b0;
			for (int j = i + 1; j < int'(count_m); j++)
				if (symbol(j) == s) return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the reader by one character; done is set when a result is formed
	task automatic read_char(input logic [ttoi_pkg::CH_W-1:0] c, input logic last,
			output logic done, output result_t res);
		int pos;
		done = 1'b0;
		res  = '0;
		pos  = digit_of(c);
		case (phase_m)
			ttoi_pkg::PH_SPACE: begin
				if (blank(c)) begin
				end else if ((c == ttoi_pkg::CHR_PLUS) || (c == ttoi_pkg::CHR_MINUS)) begin
					neg_m   = (c == ttoi_pkg::CHR_MINUS);
					phase_m = ttoi_pkg::PH_DIGITS;
				end else if (pos >= 0) begin
					acc_m   = acc_m * 64'(count_m) + 64'(pos);
					phase_m = ttoi_pkg::PH_DIGITS;
				end else begin
					phase_m = ttoi_pkg::PH_STOP;
				end
			end
			ttoi_pkg::PH_DIGITS: begin
				if (pos >= 0) acc_m = acc_m * 64'(count_m) + 64'(pos);
				else phase_m = ttoi_pkg::PH_STOP;
			end
			default: ;
		endcase
		if (last) begin
			done = 1'b1;
			if (alphabet_good()) begin
				res.value   = neg_m ? -acc_m : acc_m;
				res.base_ok = 1'b1;
			end
			phase_m = ttoi_pkg::PH_SPACE;
			neg_m   = 1'b0;
			acc_m   = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_n, what, got, want);
		errors++;
	endtask

	// check result items, then predict from accepted characters
	always @(posedge clk) begin : watch
		result_t want;
		result_t calc;
		logic    done;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result item with none expected", m_tdata, '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want.value)
						report_mismatch("value", m_tdata, want.value);
					if (m_tuser !== want.base_ok)
						report_mismatch("base_ok", 64'(m_tuser), 64'(want.base_ok));
				end
			end
			if (s_tvalid && s_tready) begin
				read_char(s_tdata, s_tlast, done, calc);
				if (done) pending_results.push_back(use_fixed ? fixed_res : calc);
			end
		end
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("FAIL text_to_integer_any_base_core");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && bursty && ($urandom_range(0, 9) == 0)) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// offer one character and wait until it is taken
	task automatic send_item(input logic [ttoi_pkg::CH_W-1:0] c, input logic last,
			input logic fixed, input result_t res);
		@(negedge clk);
		if (!calm && bursty && ($urandom_range(0, 7) == 0)) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		use_fixed = fixed;
		fixed_res = res;
		s_tdata  <= c;
		s_tlast  <= last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop sending and let every expected result come out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic [ttoi_pkg::REG_IDX_W-1:0] idx,
			input logic [ttoi_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			ttoi_pkg::REG_ALPHA_LO: alpha_lo_m = data;
			ttoi_pkg::REG_ALPHA_HI: alpha_hi_m = data;
			ttoi_pkg::REG_COUNT:    count_m    = data[ttoi_pkg::CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// new alphabet: distinct usable symbols, now and then spoilt, with a chosen radix
	task automatic pick_alphabet(input int n);
		logic [ttoi_pkg::CH_W-1:0]      syms[ttoi_pkg::SYM_LIMIT];
		logic [2*ttoi_pkg::ALPHA_W-1:0] all_syms;
		logic [ttoi_pkg::CNT_W-1:0]     cnt;
		logic [ttoi_pkg::CH_W-1:0]      b;
		logic                           clash;
		int                             k;
		int                             r;
		case (n)
			0: cnt = 5'd16;
			1: cnt = ttoi_pkg::MIN_DIGITS;
			2: cnt = 5'd31;
			3: cnt = 5'd0;
			default: begin
				r = $urandom_range(0, 9);
				if (r < 7) cnt = 5'($urandom_range(2, 16));
				else if (r == 7) cnt = 5'($urandom_range(0, 1));
				else cnt = 5'($urandom_range(17, 31));
			end
		endcase
		for (int i = 0; i < ttoi_pkg::SYM_LIMIT; i++) begin
			do begin
				b = 8'($urandom_range(1, 255));
				clash = blank(b) || (b == ttoi_pkg::CHR_PLUS) || (b == ttoi_pkg::CHR_MINUS);
				for (int j = 0; j < i; j++)
					if (syms[j] == b) clash = 1'b1;
			end while (clash);
			syms[i] = b;
		end
		// spoil one symbol in use
		if ((cnt >= ttoi_pkg::MIN_DIGITS) && (cnt <= ttoi_pkg::SYM_LIMIT) &&
				($urandom_range(0, 3) == 0)) begin
			k = $urandom_range(0, cnt - 1);
			case ($urandom_range(0, 4))
				0: syms[k] = ttoi_pkg::CHR_NUL;
				1: syms[k] = 8'($urandom_range(ttoi_pkg::CHR_TAB, ttoi_pkg::CHR_CR));
				2: syms[k] = ttoi_pkg::CHR_BLANK;
				3: syms[k] = $urandom_range(0, 1) ? ttoi_pkg::CHR_PLUS : ttoi_pkg::CHR_MINUS;
				default: syms[k] = syms[(k + 1 + $urandom_range(0, cnt - 2)) % cnt];
			endcase
		end
		for (int i = 0; i < ttoi_pkg::SYM_LIMIT; i++) all_syms[8*i +: 8] = syms[i];
		reg_write(ttoi_pkg::REG_ALPHA_LO, all_syms[ttoi_pkg::ALPHA_W-1:0]);
		reg_write(ttoi_pkg::REG_ALPHA_HI, all_syms[2*ttoi_pkg::ALPHA_W-1:ttoi_pkg::ALPHA_W]);
		if ($urandom_range(0, 7) == 0) reg_write(REG_SPARE, {$urandom, $urandom});
		reg_write(ttoi_pkg::REG_COUNT, 64'(cnt) | ({$urandom, $urandom} << ttoi_pkg::CNT_W));
	endtask

	// one string: mostly spaces, sign and digits with a broken tail now and then
	task automatic send_string();
		logic [ttoi_pkg::CH_W-1:0] text[$];
		int                        used;
		int                        n;
		int                        r;
		used = (count_m > ttoi_pkg::SYM_LIMIT) ? ttoi_pkg::SYM_LIMIT : int'(count_m);
		if ((used == 0) || ($urandom_range(0, 9) == 0)) begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) begin
				r = $urandom_range(0, 6);
				text.push_back((r == 6) ? ttoi_pkg::CHR_BLANK : ttoi_pkg::CHR_TAB + 8'(r));
			end
			case ($urandom_range(0, 3))
				0: text.push_back(ttoi_pkg::CHR_PLUS);
				1: text.push_back(ttoi_pkg::CHR_MINUS);
				default: ;
			endcase
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			repeat (n) text.push_back(symbol($urandom_range(0, used - 1)));
			r = $urandom_range(0, 7);
			case (r)
				0: text.push_back($urandom_range(0, 1) ? ttoi_pkg::CHR_PLUS :
					ttoi_pkg::CHR_MINUS);
				1: text.push_back(ttoi_pkg::CHR_NUL);
				2: text.push_back(8'($urandom_range(0, 255)));
				default: ;
			endcase
			if (r <= 2)
				repeat ($urandom_range(1, 3)) text.push_back(symbol($urandom_range(0, used - 1)));
		end
		foreach (text[k]) send_item(text[k], k == text.size() - 1, 1'b0, '0);
		items_n += text.size();
	endtask

	function automatic row_t reg_row(input logic [ttoi_pkg::REG_IDX_W-1:0] idx,
			input logic [ttoi_pkg::DATA_W-1:0] data);
		row_t r = '0;
		r.is_reg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic row_t chr_row(input logic [ttoi_pkg::CH_W-1:0] c, input logic last);
		row_t r = '0;
		r.ch   = c;
		r.last = last;
		return r;
	endfunction

	function automatic row_t fixed_row(input logic [ttoi_pkg::CH_W-1:0] c,
			input logic [ttoi_pkg::VALUE_W-1:0] v, input logic ok);
		row_t r = '0;
		r.ch          = c;
		r.last        = 1'b1;
		r.fixed       = 1'b1;
		r.res.value   = v;
		r.res.base_ok = ok;
		return r;
	endfunction

	initial begin
		row_t rows[$];
		int   phase_n;
		int   strings;

		rows = '{
			// registers still at reset: no alphabet
			fixed_row("7", 64'd0, 1'b0),
			// decimal
			reg_row(ttoi_pkg::REG_ALPHA_LO, 64'h3736353433323130),
			reg_row(ttoi_pkg::REG_ALPHA_HI, 64'h0000000000003938),
			reg_row(ttoi_pkg::REG_COUNT, 64'd10),
			reg_row(REG_SPARE, '1),
			// whitespace, minus, digits
			chr_row(ttoi_pkg::CHR_TAB, 1'b0), chr_row(ttoi_pkg::CHR_CR, 1'b0),
			chr_row(ttoi_pkg::CHR_BLANK, 1'b0), chr_row(ttoi_pkg::CHR_MINUS, 1'b0),
			chr_row("4", 1'b0), fixed_row("2", -64'sd42, 1'b1),
			// plus, then a non-symbol ends reading
			chr_row(ttoi_pkg::CHR_PLUS, 1'b0), chr_row("7", 1'b0), chr_row("x", 1'b0),
			fixed_row("9", 64'd7, 1'b1),
			// second sign stops reading
			chr_row(ttoi_pkg::CHR_MINUS, 1'b0), chr_row(ttoi_pkg::CHR_PLUS, 1'b0),
			fixed_row("5", 64'd0, 1'b1),
			// byte zero stops reading
			chr_row("1", 1'b0), chr_row(ttoi_pkg::CHR_NUL, 1'b0), fixed_row("2", 64'd1, 1'b1),
			// top byte, and whitespace alone
			fixed_row(8'hff, 64'd0, 1'b1),
			fixed_row(ttoi_pkg::CHR_BLANK, 64'd0, 1'b1),
			// sixteen symbols
			reg_row(ttoi_pkg::REG_ALPHA_HI, 64'h6665646362613938),
			reg_row(ttoi_pkg::REG_COUNT, 64'd16),
			chr_row(ttoi_pkg::CHR_MINUS, 1'b0), fixed_row("f", -64'sd15, 1'b1),
			// radix above the limit, radix one, plus among the symbols
			reg_row(ttoi_pkg::REG_COUNT, 64'd17),
			fixed_row("1", 64'd0, 1'b0),
			reg_row(ttoi_pkg::REG_COUNT, 64'd1),
			fixed_row("0", 64'd0, 1'b0),
			reg_row(ttoi_pkg::REG_ALPHA_LO, 64'h3736353433322b30),
			reg_row(ttoi_pkg::REG_COUNT, 64'd10),
			fixed_row("0", 64'd0, 1'b0),
			// back to plain decimal, read by the predictor
			reg_row(ttoi_pkg::REG_ALPHA_LO, 64'h3736353433323130),
			chr_row("9", 1'b0), chr_row("0", 1'b0), chr_row(ttoi_pkg::CHR_BLANK, 1'b1)
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (rows[k]) begin
			if (rows[k].is_reg) begin
				drain();
				reg_write(rows[k].idx, rows[k].data);
			end else begin
				send_item(rows[k].ch, rows[k].last, rows[k].fixed, rows[k].res);
			end
		end

		// random alphabets, each followed by a batch of strings
		phase_n = 0;
		while (items_n < RANDOM_ITEMS) begin
			drain();
			pick_alphabet(phase_n);
			bursty  = ($urandom_range(0, 3) != 0);
			strings = $urandom_range(4, 16);
			for (int s = 0; (s < strings) && (items_n < RANDOM_ITEMS); s++) begin
				if (items_n >= CALM_AFTER) calm = 1'b1;
				send_string();
			end
			phase_n++;
		end

		drain();
		if (errors == 0) begin
			$display("PASS text_to_integer_any_base_core");
		end else begin
			$display("FAIL text_to_integer_any_base_core");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: text_to_integer_any_base_core.f
rtl/ttoi_pkg.sv
rtl/ttoi_cfg.sv
rtl/ttoi_front.sv
rtl/ttoi_queue.sv
rtl/ttoi_back.sv
rtl/text_to_integer_any_base_core.sv
rtl/ttoi_checker.sv
test/text_to_integer_any_base_core_tb.sv
